// ===== rtl/bvc_pkg.sv =====
// Shared types and constants of the base64 / key-shift codec.
`timescale 1ns / 1ps

package bvc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       end_of_message;
  } out_word_t;

  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_KEY_LEN = 3'd1,
    CFG_KEY_0   = 3'd2,
    CFG_KEY_1   = 3'd3,
    CFG_KEY_2   = 3'd4,
    CFG_KEY_3   = 3'd5,
    CFG_KEY_4   = 3'd6,
    CFG_KEY_5   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam int unsigned KeyLenW = 6;
  localparam int unsigned MaxChars = 4;

  typedef struct packed {
    op_e                        op;
    logic [MaxChars-1:0][7:0]   chars;
    logic [2:0]                 count;
    logic                       last;
  } entry_t;

endpackage

// ===== rtl/bvc_fifo.sv =====
// Small register queue between the front and the back of the codec.
`timescale 1ns / 1ps

module bvc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/bvc_front.sv =====
// Front end: accepts input words and packs them into encode or decode queue entries.
`timescale 1ns / 1ps

module bvc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  bvc_pkg::mode_e    mode_i,
  input  logic              push_i,
  input  bvc_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output bvc_pkg::entry_t   entry_o
);

  import bvc_pkg::*;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_TWO,
    RES_FOUR
  } res_e;

  res_e       res_q, res_d;
  logic [3:0] rem_q, rem_d;
  logic [1:0] phase_q, phase_d;
  logic [5:0] sext0, sext1, flush_sext;
  logic       two, flush, last, accept;
  logic [2:0] nchar, total;
  logic [1:0] pads;
  logic [7:0] byte_in;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + 8'(v);
    end else if (v < 6'd52) begin
      c = 8'h61 + 8'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + 8'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  assign byte_in = in_word_i.data_byte;
  assign last    = in_word_i.last_in_message;
  assign accept  = push_i && !q_full_i;
  assign q_wr_o  = accept;

  always_comb begin
    sext1 = '0;
    two   = 1'b0;
    unique case (res_q)
      RES_TWO: begin
        sext0 = {rem_q[1:0], byte_in[7:4]};
        rem_d = byte_in[3:0];
        res_d = RES_FOUR;
      end
      RES_FOUR: begin
        sext0 = {rem_q, byte_in[7:6]};
        sext1 = byte_in[5:0];
        two   = 1'b1;
        rem_d = '0;
        res_d = RES_NONE;
      end
      default: begin
        sext0 = byte_in[7:2];
        rem_d = {2'b00, byte_in[1:0]};
        res_d = RES_TWO;
      end
    endcase

    flush      = last && (res_d != RES_NONE);
    flush_sext = (res_d == RES_TWO) ? {rem_d[1:0], 4'b0000} : {rem_d, 2'b00};
    nchar      = (two ? 3'd2 : 3'd1) + {2'b00, flush};
    phase_d    = phase_q + nchar[1:0];
    pads       = last ? (2'd0 - phase_d) : 2'd0;
    total      = nchar + {1'b0, pads};

    entry_o.last = last;
    if (mode_i == MODE_DECRYPT) begin
      entry_o.op       = OP_DECODE;
      entry_o.chars    = {MaxChars{PadChar}};
      entry_o.chars[0] = byte_in;
      entry_o.count    = 3'd1;
    end else begin
      entry_o.op       = OP_ENCODE;
      entry_o.chars    = {MaxChars{PadChar}};
      entry_o.chars[0] = b64_char(sext0);
      if (two) begin
        entry_o.chars[1] = b64_char(sext1);
      end else if (flush) begin
        entry_o.chars[1] = b64_char(flush_sext);
      end
      if (two && flush) begin
        entry_o.chars[2] = b64_char(flush_sext);
      end
      entry_o.count = (total > 3'(MaxChars)) ? 3'(MaxChars) : total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= RES_NONE;
      rem_q   <= '0;
      phase_q <= '0;
    end else if (clr_i || (accept && last)) begin
      res_q   <= RES_NONE;
      rem_q   <= '0;
      phase_q <= '0;
    end else if (accept && (mode_i == MODE_ENCRYPT)) begin
      res_q   <= res_d;
      rem_q   <= rem_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/bvc_back.sv =====
// Back end: key shift per character, base64 decode and the output word register.
`timescale 1ns / 1ps

module bvc_back #(
  parameter int unsigned KEY_MAX  = 48,
  parameter int unsigned KEY_ROWS = (KEY_MAX + 7) / 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   clr_i,
  input  logic [bvc_pkg::KeyLenW-1:0]            key_len_i,
  input  logic [KEY_ROWS-1:0][63:0]              key_rows_i,
  input  bvc_pkg::entry_t                        head_i,
  input  logic                                   head_valid_i,
  output logic                                   head_pop_o,
  input  logic                                   pop_i,
  output logic                                   empty_o,
  output bvc_pkg::out_word_t                     out_word_o
);

  import bvc_pkg::*;

  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, res;
  logic [1:0]       sub_q, sub_d;
  logic [5:0]       pos_q, pos_d, pos_nxt;
  logic [5:0]       k_q, k_d;
  logic [1:0]       dpend_q, dpend_d;
  logic [5:0]       drem_q, drem_d;
  logic             stop_q, stop_d;
  logic             room, go, fin, emit, done;
  logic [6:0]       eff_len, ci, bv, sum;
  logic [7:0]       c_in, sh_char;

  function automatic logic [6:0] cipher_idx(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end
    return r;
  endfunction

  function automatic logic [7:0] cipher_char(input logic [5:0] i);
    logic [7:0] c;
    if (i < 6'd26) begin
      c = 8'h61 + 8'(i);
    end else if (i < 6'd52) begin
      c = 8'h41 + 8'(i - 6'd26);
    end else begin
      c = 8'h30 + 8'(i - 6'd52);
    end
    return c;
  endfunction

  function automatic logic [6:0] b64_val(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [5:0] key_shift(input logic [5:0] pos,
                                           input logic [KEY_ROWS-1:0][63:0] rows);
    logic [63:0] row;
    logic [7:0]  kc;
    logic [6:0]  ki;
    row = '0;
    for (int r = 0; r < KEY_ROWS; r++) begin
      if (pos[5:3] == 3'(r)) begin
        row = rows[r];
      end
    end
    kc = row[{pos[2:0], 3'b000} +: 8];
    ki = cipher_idx(kc);
    return ki[6] ? ki[5:0] : 6'd0;
  endfunction

  assign room       = !out_valid_q || pop_i;
  assign go         = head_valid_i && room;
  assign fin        = ({1'b0, sub_q} + 3'd1) >= head_i.count;
  assign head_pop_o = go && fin;
  assign done       = go && fin && head_i.last;
  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  assign eff_len = (key_len_i == '0) ? 7'd1 :
                   ({1'b0, key_len_i} > 7'(KEY_MAX)) ? 7'(KEY_MAX) : {1'b0, key_len_i};
  assign pos_nxt = (({1'b0, pos_q} + 7'd1) >= eff_len) ? '0 : pos_q + 6'd1;

  always_comb begin
    c_in = head_i.chars[sub_q];
    ci   = cipher_idx(c_in);
    if (head_i.op == OP_ENCODE) begin
      sum = {1'b0, ci[5:0]} + {1'b0, k_q};
    end else begin
      sum = {1'b0, ci[5:0]} + 7'd62 - {1'b0, k_q};
    end
    if (sum >= 7'd62) begin
      sum = sum - 7'd62;
    end
    sh_char = ci[6] ? cipher_char(sum[5:0]) : c_in;
    bv      = b64_val(sh_char);

    emit    = 1'b0;
    res     = '0;
    dpend_d = dpend_q;
    drem_d  = drem_q;
    stop_d  = stop_q;

    if (head_i.op == OP_ENCODE) begin
      emit               = 1'b1;
      res.out_byte       = sh_char;
      res.has_data       = 1'b1;
      res.end_of_message = head_i.last && fin;
    end else begin
      if (!stop_q) begin
        if (!bv[6]) begin
          stop_d = 1'b1;
        end else begin
          unique case (dpend_q)
            2'd0: begin
              drem_d  = bv[5:0];
              dpend_d = 2'd3;
            end
            2'd1: begin
              emit         = 1'b1;
              res.out_byte = {drem_q[1:0], bv[5:0]};
              drem_d       = '0;
              dpend_d      = 2'd0;
            end
            2'd2: begin
              emit         = 1'b1;
              res.out_byte = {drem_q[3:0], bv[5:2]};
              drem_d       = {4'b0000, bv[1:0]};
              dpend_d      = 2'd1;
            end
            2'd3: begin
              emit         = 1'b1;
              res.out_byte = {drem_q, bv[5:4]};
              drem_d       = {2'b00, bv[3:0]};
              dpend_d      = 2'd2;
            end
          endcase
        end
      end
      res.has_data = emit;
      if (head_i.last) begin
        emit               = 1'b1;
        res.end_of_message = 1'b1;
      end
    end

    if (clr_i || done) begin
      pos_d   = '0;
      sub_d   = '0;
      dpend_d = '0;
      drem_d  = '0;
      stop_d  = 1'b0;
    end else if (go) begin
      pos_d = pos_nxt;
      sub_d = fin ? 2'd0 : sub_q + 2'd1;
    end else begin
      pos_d   = pos_q;
      sub_d   = sub_q;
      dpend_d = dpend_q;
      drem_d  = drem_q;
      stop_d  = stop_q;
    end

    k_d         = key_shift(pos_d, key_rows_i);
    out_valid_d = room ? (go && emit) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      dpend_q     <= '0;
      drem_q      <= '0;
      stop_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      dpend_q     <= dpend_d;
      drem_q      <= drem_d;
      stop_q      <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < 7'(KEY_MAX))
    else $error("key position out of range");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (pos_q == '0 && dpend_q == '0 && !stop_q && sub_q == '0))
    else $error("stream state not cleared after end of message");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && head_i.op == OP_DECODE && stop_q) |-> !(emit && res.has_data))
    else $error("data word after decode stopped");

  a_sub_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ({1'b0, sub_q} < head_i.count))
    else $error("character index beyond entry");
`endif

endmodule

// ===== rtl/base64_vigenere_codec.sv =====
// Top level of the base64 codec with repeating-key character shift.
//
//   channel   direction  handshake                 word
//   input     in         push_i / full_o           in_word_i (data_byte, last_in_message)
//   result    out        pop_i / empty_o           out_word_o (out_byte, has_data, end_of_message)
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The front takes one input word per cycle while the queue is not full; the back shifts
// each character in turn, so an encrypt byte yields 1 to 4 characters (4 per 3 bytes on
// average) and a decrypt byte one. A result passes the queue, then the output word register.
// Reset clears configuration (encrypt, key length 1, key zero) and all stream state.
// A 4-entry queue parts front and back: full_o rises when it fills; the back holds
// while the output word is not popped.
`timescale 1ns / 1ps

module base64_vigenere_codec #(
  parameter int unsigned KEY_MAX    = 48,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  bvc_pkg::in_word_t  in_word_i,
  input  logic               pop_i,
  output logic               empty_o,
  output bvc_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  import bvc_pkg::*;

  localparam int unsigned KeyRows = (KEY_MAX + 7) / 8;
  localparam int unsigned EntryW  = $bits(entry_t);

  mode_e                    mode_q;
  logic [KeyLenW-1:0]       key_len_q;
  logic [KeyRows-1:0][63:0] key_rows_q;
  logic                     cfg_wr, clr;
  cfg_reg_e                 cfg_reg;
  logic [2:0]               key_row_sel;

  logic                     q_wr, q_full, q_empty, q_rd;
  entry_t                   q_wentry, q_head;
  logic [EntryW-1:0]        q_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);
  assign key_row_sel = cfg_index_i - 3'(CFG_KEY_0);
  assign clr         = cfg_wr && (cfg_reg == CFG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ENCRYPT;
      key_len_q  <= KeyLenW'(1);
      key_rows_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[0]);
        CFG_KEY_LEN: key_len_q <= cfg_data_i[KeyLenW-1:0];
        CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3, CFG_KEY_4, CFG_KEY_5: begin
          for (int r = 0; r < KeyRows; r++) begin
            if (key_row_sel == 3'(r)) begin
              key_rows_q[r] <= cfg_data_i;
            end
          end
        end
      endcase
    end
  end

  assign full_o = q_full;
  assign q_head = entry_t'(q_rdata);

  bvc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .mode_i    (mode_q),
    .push_i    (push_i),
    .in_word_i (in_word_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .entry_o   (q_wentry)
  );

  bvc_fifo #(
    .WIDTH (EntryW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wentry),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  bvc_back #(
    .KEY_MAX  (KEY_MAX),
    .KEY_ROWS (KeyRows)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (clr),
    .key_len_i    (key_len_q),
    .key_rows_i   (key_rows_q),
    .head_i       (q_head),
    .head_valid_i (!q_empty),
    .head_pop_o   (q_rd),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_word_o   (out_word_o)
  );

endmodule

// ===== tb/sv/bvc_checker.sv =====
// Checker of the base64 / key-shift codec: predicts result words and compares them.
`timescale 1ns / 1ps

module bvc_checker
  import bvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  in_word_t   in_word_i,
  input  logic       pop_i,
  input  logic       empty_i,
  input  out_word_t  out_word_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int         mismatches_o,
  output int         pending_o,
  output int         compared_o
);

  localparam int KeyMax = 48;

  mode_e       mode_q;
  logic [5:0]  key_len_q;
  logic [7:0]  key_q [KeyMax];
  logic [15:0] acc_q;
  logic [4:0]  nbits_q;
  logic [5:0]  kpos_q;
  logic [1:0]  phase_q;
  logic        stopped_q;

  out_word_t   step_q [$];
  out_word_t   expect_q [$];
  int          mismatches;
  int          compared;

  function automatic int alnum_index(logic [7:0] c);
    if (c >= "a" && c <= "z") return int'(c) - int'("a");
    if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    return -1;
  endfunction

  function automatic logic [7:0] alnum_char(int i);
    if (i < 26) return 8'(int'("a") + i);
    if (i < 52) return 8'(int'("A") + i - 26);
    return 8'(int'("0") + i - 52);
  endfunction

  function automatic int b64_index(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(logic [5:0] v);
    if (v < 26) return 8'(int'("A") + int'(v));
    if (v < 52) return 8'(int'("a") + int'(v) - 26);
    if (v < 62) return 8'(int'("0") + int'(v) - 52);
    return (v == 6'd62) ? "+" : "/";
  endfunction

  // Shift one character by the current key character and advance the key position.
  function automatic logic [7:0] key_shift(logic [7:0] c, logic fwd);
    int k;
    int i;
    int n;
    n = (key_len_q == 0) ? 1 : (key_len_q > KeyMax) ? KeyMax : int'(key_len_q);
    k = (kpos_q < KeyMax) ? alnum_index(key_q[kpos_q]) : -1;
    kpos_q = (int'(kpos_q) + 1 >= n) ? 6'd0 : kpos_q + 6'd1;
    if (k < 0) k = 0;
    i = alnum_index(c);
    if (i < 0) return c;
    return fwd ? alnum_char((i + k) % 62) : alnum_char((i + 62 - k) % 62);
  endfunction

  function automatic void clear_stream();
    acc_q = '0;
    nbits_q = '0;
    kpos_q = '0;
    phase_q = '0;
    stopped_q = 1'b0;
  endfunction

  function automatic void add_word(logic [7:0] b, logic has);
    if (step_q.size() < MaxChars)
      step_q.insert(step_q.size(),
                    out_word_t'{out_byte: b, has_data: has, end_of_message: 1'b0});
  endfunction

  function automatic void emit_char(logic [7:0] c);
    add_word(key_shift(c, 1'b1), 1'b1);
    phase_q = phase_q + 2'd1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    case (cfg_reg_e'(idx))
      CFG_MODE: begin
        mode_q = mode_e'(d[0]);
        clear_stream();
      end
      CFG_KEY_LEN: key_len_q = d[5:0];
      default: begin
        for (int b = 0; b < 8; b++) key_q[(int'(idx) - int'(CFG_KEY_0)) * 8 + b] = d[8*b +: 8];
      end
    endcase
  endtask

  task automatic predict_word(in_word_t w);
    int v;
    logic [7:0] c;
    step_q.delete();
    if (mode_q == MODE_ENCRYPT) begin
      acc_q = {acc_q[7:0], w.data_byte};
      nbits_q = nbits_q + 5'd8;
      while (nbits_q >= 6 && nbits_q <= 16) begin
        nbits_q = nbits_q - 5'd6;
        emit_char(b64_char(6'(acc_q >> nbits_q)));
      end
      if (w.last_in_message) begin
        if (nbits_q > 0 && nbits_q < 6) emit_char(b64_char(6'(acc_q << (6 - nbits_q))));
        while (phase_q != 2'd0 && step_q.size() < MaxChars) emit_char(PadChar);
      end
    end else begin
      c = key_shift(w.data_byte, 1'b0);
      if (!stopped_q) begin
        v = b64_index(c);
        if (v < 0) begin
          stopped_q = 1'b1;
        end else begin
          acc_q = {acc_q[9:0], 6'(v)};
          nbits_q = nbits_q + 5'd6;
          if (nbits_q >= 8 && nbits_q <= 16) begin
            nbits_q = nbits_q - 5'd8;
            add_word(8'(acc_q >> nbits_q), 1'b1);
          end
        end
      end
      if (w.last_in_message && step_q.size() == 0) add_word(8'h00, 1'b0);
    end
    if (w.last_in_message) begin
      if (step_q.size() > 0) step_q[step_q.size() - 1].end_of_message = 1'b1;
      clear_stream();
    end
    foreach (step_q[i]) expect_q.insert(expect_q.size(), step_q[i]);
  endtask

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t bvc_checker: %s", $realtime, msg);
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    compared++;
    if (expect_q.size() == 0) begin
      flag($sformatf("word %0d unexpected: byte %02h has_data %0b end %0b",
                     compared, got.out_byte, got.has_data, got.end_of_message));
    end else begin
      want = expect_q.pop_front();
      if (got.out_byte !== want.out_byte || got.has_data !== want.has_data ||
          got.end_of_message !== want.end_of_message)
        flag($sformatf("word %0d: expected byte %02h has_data %0b end %0b, got %02h %0b %0b",
                       compared, want.out_byte, want.has_data, want.end_of_message,
                       got.out_byte, got.has_data, got.end_of_message));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_ENCRYPT;
      key_len_q = 6'd1;
      foreach (key_q[i]) key_q[i] = '0;
      clear_stream();
      expect_q.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (pop_i && !empty_i) check_word(out_word_i);
      if (push_i && !full_i) predict_word(in_word_i);
    end
    mismatches_o <= mismatches;
    pending_o <= expect_q.size();
    compared_o <= compared;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the base64 / key-shift codec: drives words and configuration, gives the verdict.
`timescale 1ns / 1ps

module tb;
  import bvc_pkg::*;

  localparam int CycleLimit = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  in_word_t   in_word_i = '0;
  logic       pop_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic       full_o;
  logic       empty_o;
  logic       cfg_ready_o;
  out_word_t  out_word_o;

  int mismatches;
  int pending;
  int compared;
  int sent = 0;
  int cycles = 0;
  int send_idle = 37;
  int recv_idle = 68;
  logic [63:0] key_word [6];
  logic [5:0]  len_plan [9] = '{6'd1, 6'd48, 6'd17, 6'd0, 6'd63, 6'd5, 6'd48, 6'd1, 6'd0};

  base64_vigenere_codec i_dut (
    .clk_i, .rst_ni, .push_i, .full_o, .in_word_i, .pop_i, .empty_o, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  bvc_checker i_checker (
    .clk_i, .rst_ni, .push_i, .full_i(full_o), .in_word_i, .pop_i, .empty_i(empty_o),
    .out_word_i(out_word_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .mismatches_o(mismatches), .pending_o(pending), .compared_o(compared)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pop_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'(int'("a") + r);
    if (r < 52) return 8'(int'("A") + r - 26);
    return 8'(int'("0") + r - 52);
  endfunction

  // Mostly base64 characters, now and then a pad, a space or any byte.
  function automatic logic [7:0] cipher_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return pick_alnum();
    if (r < 92) return (r == 90) ? "+" : "/";
    if (r < 96) return (r < 94) ? "=" : " ";
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_word_i <= {b, last};
    do @(posedge clk_i); while (full_o);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_message(mode_e m);
    int len;
    logic noisy;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++)
      send_word((m == MODE_ENCRYPT || noisy) ? 8'($urandom_range(0, 255)) : cipher_char(),
                i == len - 1);
  endtask

  // Hold the sender until every expected word is back, then let the pipe settle.
  task automatic drain();
    push_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_put(cfg_reg_e idx, logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(mode_e m, logic [5:0] len);
    cfg_put(CFG_MODE, 64'(m));
    cfg_put(CFG_KEY_LEN, 64'(len));
    for (int k = 0; k < 6; k++) cfg_put(cfg_reg_e'(int'(CFG_KEY_0) + k), key_word[k]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic roll_keys();
    for (int k = 0; k < 6; k++)
      for (int b = 0; b < 8; b++)
        key_word[k][8*b +: 8] = ($urandom_range(0, 99) < 80) ? pick_alnum()
                                                              : 8'($urandom_range(0, 255));
  endtask

  initial begin
    mode_e m;
    int target;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    key_word[0] = 64'h0000_0000_0039_5A62;
    for (int k = 1; k < 6; k++) key_word[k] = '1;
    configure(MODE_ENCRYPT, 6'd4);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h7F, 1'b1);
    send_word(8'h41, 1'b0);
    drain();
    configure(MODE_ENCRYPT, 6'd0);
    send_word(8'hC3, 1'b0);
    send_word(8'h3C, 1'b1);
    drain();
    configure(MODE_ENCRYPT, 6'd63);
    send_word(8'h5A, 1'b1);
    drain();
    configure(MODE_DECRYPT, 6'd4);
    send_text("QUJD");
    send_text("+/ x9");
    send_text("a=");

    for (int s = 0; s < 9; s++) begin
      if (s == 3) begin
        send_idle = 68;
        recv_idle = 37;
      end
      if (s == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      m = mode_e'(s[0]);
      drain();
      roll_keys();
      configure(m, (s == 8) ? 6'($urandom_range(1, 48)) : len_plan[s]);
      target = sent + 38;
      while (sent < target) send_message(m);
    end

    drain();
    $display("tb: %0d input words sent, %0d result words compared", sent, compared);
    $display("tb: both modes, key lengths 0 to 63, padding, early stop, idling on either side");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bvc_pkg.sv
rtl/bvc_fifo.sv
rtl/bvc_front.sv
rtl/bvc_back.sv
rtl/base64_vigenere_codec.sv
tb/sv/bvc_checker.sv
tb/sv/tb.sv
